// ===== rtl/mdb_pkg.sv =====
`default_nettype none

package mdb_pkg;

  // Magnitude format: unsigned fixed point with FRAC_BITS fraction bits.
  localparam int MAG_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = $clog2(MAG_WIDTH);

  // The log2 fraction comes from the six bits just below the leading one.
  localparam int TAB_BITS  = 6;
  localparam int TAB_DEPTH = 1 << TAB_BITS;

  // log2 in signed Q.8 and the dB value (log2 * 1541 / 256) in signed Q8.8.
  localparam int L2_W    = POS_W + 10;
  localparam int DB_MULT = 1541;
  localparam int PROD_W  = L2_W + 12;
  localparam int DB_W    = PROD_W - 8;
  localparam int NUM_W   = DB_W + 1;

  // Configuration registers.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_FLOOR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DB_CEILING = CFG_IDX_W'(1);
  localparam logic signed [CFG_W-1:0] DB_FLOOR_RST   = -16'sd20480;
  localparam logic signed [CFG_W-1:0] DB_CEILING_RST = 16'sd0;
  localparam int RANGE_W = CFG_W + 1;

  // Normalized level t in Q1.16, 0..65536, and its restoring divider.
  localparam int Q_W           = 16;
  localparam int T_W           = Q_W + 1;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = Q_W / BITS_PER_STEP;

  // Colour map.
  localparam int PALETTE_STOPS = 16;
  localparam int PAL_IDX_W     = $clog2(PALETTE_STOPS);
  localparam int X_W           = T_W + PAL_IDX_W;
  localparam int CH_W          = 8;

  typedef logic [7:0] frac_tab_t [TAB_DEPTH];

  // round(256 * log2(1 + idx / 64))
  localparam frac_tab_t LOG2_FRAC_TAB = '{
      8'd0,   8'd6,   8'd11,  8'd17,  8'd22,  8'd28,  8'd33,  8'd38,
      8'd44,  8'd49,  8'd54,  8'd59,  8'd63,  8'd68,  8'd73,  8'd78,
      8'd82,  8'd87,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113,
      8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
      8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd169, 8'd172, 8'd176,
      8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
      8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
      8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
  };

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef rgb_t palette_t [PALETTE_STOPS];

  localparam palette_t PALETTE = '{
      '{8'd68,  8'd1,   8'd84},  '{8'd72,  8'd35,  8'd116},
      '{8'd64,  8'd67,  8'd135}, '{8'd52,  8'd94,  8'd141},
      '{8'd41,  8'd120, 8'd142}, '{8'd32,  8'd144, 8'd140},
      '{8'd34,  8'd167, 8'd132}, '{8'd68,  8'd190, 8'd112},
      '{8'd121, 8'd209, 8'd81},  '{8'd189, 8'd222, 8'd38},
      '{8'd253, 8'd231, 8'd36},  '{8'd253, 8'd200, 8'd39},
      '{8'd253, 8'd168, 8'd46},  '{8'd251, 8'd134, 8'd56},
      '{8'd243, 8'd96,  8'd60},  '{8'd221, 8'd50,  8'd60}
  };

  // How the level t is formed once the clamping has been decided.
  typedef enum logic [1:0] {
    TSEL_ZERO,
    TSEL_FULL,
    TSEL_DIV
  } tsel_t;

  // One word in flight through the divider.
  typedef struct packed {
    tsel_t          sel;
    logic [Q_W-1:0] rem;
    logic [Q_W-1:0] den;
    logic [Q_W-1:0] quo;
  } div_word_t;

endpackage

`default_nettype wire

// ===== rtl/mdb_log.sv =====
`default_nettype none

module mdb_log
  import mdb_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [MAG_WIDTH-1:0]        in_mag,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [DB_W-1:0]      out_db,
  output logic                        out_nz
);

  localparam int NSTG = 4;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  // Stage 1: leading-one position.
  logic [MAG_WIDTH-1:0] mag1_r, mag1_nxt;
  logic [POS_W-1:0]     pos1_r, pos1_nxt;
  logic                 nz1_r, nz1_nxt;

  // Stage 2: normalizing shift picks the table index.
  logic [TAB_BITS-1:0]  idx2_r, idx2_nxt;
  logic [POS_W-1:0]     pos2_r, pos2_nxt;
  logic                 nz2_r, nz2_nxt;
  logic [MAG_WIDTH-1:0] norm2;

  // Stage 3: log2 in Q.8.
  logic signed [L2_W-1:0] l2_3_r, l2_3_nxt;
  logic                   nz3_r, nz3_nxt;
  logic signed [L2_W-1:0] int3;

  // Stage 4: dB in Q8.8.
  logic signed [DB_W-1:0]   db4_r, db4_nxt;
  logic                     nz4_r, nz4_nxt;
  logic signed [PROD_W-1:0] prod4;

  // A stage moves on when it is empty or its successor moves on.
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Priority encoder: the highest set bit wins.
  always_comb begin
    pos1_nxt = '0;
    for (int b = 0; b < MAG_WIDTH; b++) begin
      if (in_mag[b]) begin
        pos1_nxt = POS_W'(b);
      end
    end
    nz1_nxt  = |in_mag;
    mag1_nxt = in_mag;
  end

  // Shift the leading one to the top; zeros come in from below.
  always_comb begin
    norm2    = mag1_r << (POS_W'(MAG_WIDTH - 1) - pos1_r);
    idx2_nxt = norm2[MAG_WIDTH-2 -: TAB_BITS];
    pos2_nxt = pos1_r;
    nz2_nxt  = nz1_r;
  end

  // Integer part (position less the fraction bits) plus the table fraction.
  always_comb begin
    int3     = $signed({{(L2_W - POS_W){1'b0}}, pos2_r}) - L2_W'(FRAC_BITS);
    l2_3_nxt = (int3 <<< 8) + $signed({{(L2_W - 8){1'b0}}, LOG2_FRAC_TAB[idx2_r]});
    nz3_nxt  = nz2_r;
  end

  // Scale by 1541/256; the arithmetic shift rounds towards minus infinity.
  always_comb begin
    prod4   = $signed({{(PROD_W - L2_W){l2_3_r[L2_W-1]}}, l2_3_r}) *
              $signed(PROD_W'(DB_MULT));
    db4_nxt = prod4[PROD_W-1:8];
    nz4_nxt = nz3_r;
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      mag1_r <= mag1_nxt;
      pos1_r <= pos1_nxt;
      nz1_r  <= nz1_nxt;
    end
    if (adv[1] && v_r[0]) begin
      idx2_r <= idx2_nxt;
      pos2_r <= pos2_nxt;
      nz2_r  <= nz2_nxt;
    end
    if (adv[2] && v_r[1]) begin
      l2_3_r <= l2_3_nxt;
      nz3_r  <= nz3_nxt;
    end
    if (adv[3] && v_r[2]) begin
      db4_r <= db4_nxt;
      nz4_r <= nz4_nxt;
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_db    = db4_r;
  assign out_nz    = nz4_r;

endmodule

`default_nettype wire

// ===== rtl/mdb_div_step.sv =====
`default_nettype none

module mdb_div_step
  import mdb_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  div_word_t  in_word,
  output logic       out_valid,
  input  wire        out_ready,
  output div_word_t  out_word
);

  logic      v_r;
  div_word_t word_r, word_nxt;
  logic [Q_W:0] trial;

  assign in_ready = !v_r || out_ready;

  // Restoring division, a few quotient bits per stage.
  always_comb begin
    word_nxt = in_word;
    trial    = '0;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      trial = {word_nxt.rem, 1'b0};
      if (trial >= {1'b0, word_nxt.den}) begin
        trial        = trial - {1'b0, word_nxt.den};
        word_nxt.quo = {word_nxt.quo[Q_W-2:0], 1'b1};
      end else begin
        word_nxt.quo = {word_nxt.quo[Q_W-2:0], 1'b0};
      end
      word_nxt.rem = trial[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

// ===== rtl/mdb_cmap.sv =====
`default_nettype none

module mdb_cmap
  import mdb_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  div_word_t        in_word,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [CH_W-1:0]  out_gray,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue
);

  localparam int MIX_W = CH_W + Q_W + 2;

  // Blend two channel values: lo*(1-f) + hi*f, truncated.
  function automatic logic [CH_W-1:0] mix(input logic [CH_W-1:0] lo,
                                          input logic [CH_W-1:0] hi,
                                          input logic [Q_W-1:0]  f);
    logic signed [CH_W:0]    diff;
    logic signed [MIX_W-1:0] acc;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    acc  = $signed({2'b00, lo, {Q_W{1'b0}}}) +
           $signed({{(MIX_W - CH_W - 1){diff[CH_W]}}, diff}) *
           $signed({{(MIX_W - Q_W){1'b0}}, f});
    return acc[Q_W +: CH_W];
  endfunction

  logic [1:0] v_r;
  logic [1:0] adv;

  // Stage A: level t, gray, palette stops and the blend fraction.
  logic [T_W-1:0]       t_a;
  logic [T_W+CH_W-1:0]  gray_prod;
  logic [X_W-1:0]       x_a;
  logic [X_W-Q_W-1:0]   i_full;
  logic [PAL_IDX_W-1:0] i_a, j_a;
  logic [CH_W-1:0]      gray_a_r, gray_a_nxt;
  rgb_t                 lo_a_r, lo_a_nxt;
  rgb_t                 hi_a_r, hi_a_nxt;
  logic [Q_W-1:0]       f_a_r, f_a_nxt;

  // Stage B: output register.
  logic [CH_W-1:0] gray_b_r, gray_b_nxt;
  rgb_t            rgb_b_r, rgb_b_nxt;

  always_comb begin
    adv[1] = !v_r[1] || out_ready;
    adv[0] = !v_r[0] || adv[1];
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      if (adv[1]) begin
        v_r[1] <= v_r[0];
      end
    end
  end

  // Select t and locate it between two palette stops.
  always_comb begin
    case (in_word.sel)
      TSEL_FULL: t_a = T_W'(1) << Q_W;
      TSEL_DIV:  t_a = {1'b0, in_word.quo};
      default:   t_a = '0;
    endcase
    gray_prod  = {{CH_W{1'b0}}, t_a} * (T_W + CH_W)'(255);
    gray_a_nxt = gray_prod[Q_W +: CH_W];
    x_a        = {{PAL_IDX_W{1'b0}}, t_a} * X_W'(PALETTE_STOPS - 1);
    i_full     = x_a[X_W-1:Q_W];
    if (i_full >= (X_W - Q_W)'(PALETTE_STOPS - 1)) begin
      i_a = PAL_IDX_W'(PALETTE_STOPS - 1);
      j_a = PAL_IDX_W'(PALETTE_STOPS - 1);
    end else begin
      i_a = i_full[PAL_IDX_W-1:0];
      j_a = i_full[PAL_IDX_W-1:0] + PAL_IDX_W'(1);
    end
    f_a_nxt  = x_a[Q_W-1:0];
    lo_a_nxt = PALETTE[i_a];
    hi_a_nxt = PALETTE[j_a];
  end

  // One multiplier per colour channel.
  always_comb begin
    gray_b_nxt  = gray_a_r;
    rgb_b_nxt.r = mix(lo_a_r.r, hi_a_r.r, f_a_r);
    rgb_b_nxt.g = mix(lo_a_r.g, hi_a_r.g, f_a_r);
    rgb_b_nxt.b = mix(lo_a_r.b, hi_a_r.b, f_a_r);
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      gray_a_r <= gray_a_nxt;
      lo_a_r   <= lo_a_nxt;
      hi_a_r   <= hi_a_nxt;
      f_a_r    <= f_a_nxt;
    end
    if (adv[1] && v_r[0]) begin
      gray_b_r <= gray_b_nxt;
      rgb_b_r  <= rgb_b_nxt;
    end
  end

  assign out_valid = v_r[1];
  assign out_gray  = gray_b_r;
  assign out_red   = rgb_b_r.r;
  assign out_green = rgb_b_r.g;
  assign out_blue  = rgb_b_r.b;

endmodule

`default_nettype wire

// ===== rtl/magnitude_to_db_colormap_pixel.sv =====
// Spectrogram pixel colouring: one magnitude word in, one pixel word out.
// Input channel: in_valid / in_stall with in_magnitude, unsigned, 16
// fraction bits. Output channel: out_valid / out_stall with out_gray_level
// and the colour out_red, out_green, out_blue. A word moves at a clock edge
// where valid is high and stall is low.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// is the dB floor and index 1 the dB ceiling, both signed Q8.8. Other
// indexes are ignored. cfg_ready is always high; write only while idle.
// The pipeline has four stages for the log2 and dB scaling, one for the
// clamp decision, eight divider stages (two quotient bits each) and two
// colour map stages. One word is taken every cycle unless a receiver stall
// has filled the pipeline; the 16-bit restoring divider is laid out as a
// pipeline so that it sets the depth, not the rate.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// floor with -80 dB and the ceiling with 0 dB.
// When the receiver stalls, the last word holds; earlier stages go on
// filling empty slots, and in_stall rises once every slot is occupied.
`default_nettype none

module magnitude_to_db_colormap_pixel
  import mdb_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [31:0]           in_magnitude,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [7:0]            out_gray_level,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_W-1:0]      cfg_data
);

  // Configuration registers.
  logic signed [CFG_W-1:0] floor_r, floor_nxt;
  logic signed [CFG_W-1:0] ceil_r, ceil_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    floor_nxt = floor_r;
    ceil_nxt  = ceil_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DB_FLOOR:   floor_nxt = $signed(cfg_data);
        CFG_DB_CEILING: ceil_nxt  = $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= DB_FLOOR_RST;
      ceil_r  <= DB_CEILING_RST;
    end else begin
      floor_r <= floor_nxt;
      ceil_r  <= ceil_nxt;
    end
  end

  // Log2 and dB front end.
  logic                   log_in_ready;
  logic                   log_valid;
  logic                   log_ready;
  logic signed [DB_W-1:0] log_db;
  logic                   log_nz;

  mdb_log u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (log_in_ready),
    .in_mag    (in_magnitude[MAG_WIDTH-1:0]),
    .out_valid (log_valid),
    .out_ready (log_ready),
    .out_db    (log_db),
    .out_nz    (log_nz)
  );

  assign in_stall = !log_in_ready;

  // Clamp stage: decide zero, full scale or a true division.
  logic                     norm_v_r;
  logic                     norm_ready;
  div_word_t                norm_r, norm_nxt;
  logic signed [NUM_W-1:0]   num;
  logic signed [RANGE_W-1:0] range_q;

  logic [DIV_STEPS:0] dv_valid;
  logic [DIV_STEPS:0] dv_ready;
  div_word_t          dv_word [DIV_STEPS+1];

  assign norm_ready = !norm_v_r || dv_ready[0];
  assign log_ready  = norm_ready;

  always_comb begin
    num     = $signed({{(NUM_W - DB_W){log_db[DB_W-1]}}, log_db}) -
              $signed({{(NUM_W - CFG_W){floor_r[CFG_W-1]}}, floor_r});
    range_q = $signed({ceil_r[CFG_W-1], ceil_r}) - $signed({floor_r[CFG_W-1], floor_r});
    norm_nxt.rem = num[Q_W-1:0];
    norm_nxt.den = range_q[Q_W-1:0];
    norm_nxt.quo = '0;
    if (!log_nz || range_q <= 0 || num <= 0) begin
      norm_nxt.sel = TSEL_ZERO;
    end else if (num >= $signed({{(NUM_W - RANGE_W){range_q[RANGE_W-1]}}, range_q})) begin
      norm_nxt.sel = TSEL_FULL;
    end else begin
      norm_nxt.sel = TSEL_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_v_r <= 1'b0;
    end else if (norm_ready) begin
      norm_v_r <= log_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (norm_ready && log_valid) begin
      norm_r <= norm_nxt;
    end
  end

  assign dv_valid[0] = norm_v_r;
  assign dv_word[0]  = norm_r;

  // Divider pipeline: (n << 16) / range.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    mdb_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_valid[s]),
      .in_ready  (dv_ready[s]),
      .in_word   (dv_word[s]),
      .out_valid (dv_valid[s+1]),
      .out_ready (dv_ready[s+1]),
      .out_word  (dv_word[s+1])
    );
  end

  // Gray level and colour map.
  mdb_cmap u_cmap (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid[DIV_STEPS]),
    .in_ready  (dv_ready[DIV_STEPS]),
    .in_word   (dv_word[DIV_STEPS]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_gray  (out_gray_level),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

`default_nettype wire

// ===== rtl/mdb_chk.sv =====
`default_nettype none

module mdb_chk
  import mdb_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire [31:0]           in_magnitude,
  input wire                  out_valid,
  input wire                  out_stall,
  input wire [7:0]            out_gray_level,
  input wire [7:0]            out_red,
  input wire [7:0]            out_green,
  input wire [7:0]            out_blue,
  input wire                  cfg_valid,
  input wire                  cfg_ready,
  input wire [CFG_IDX_W-1:0]  cfg_index,
  input wire [CFG_W-1:0]      cfg_data
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present just after reset");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_gray_level) &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("stalled output word changed or vanished");

  // With the receiver taking words, the whole pipeline moves.
  a_no_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
      !out_stall |-> !in_stall)
    else $error("input stalled although the output is not");

  // Full scale gray must come with the last palette stop.
  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_gray_level == 8'd255 |->
      out_red == PALETTE[PALETTE_STOPS-1].r && out_green == PALETTE[PALETTE_STOPS-1].g &&
      out_blue == PALETTE[PALETTE_STOPS-1].b)
    else $error("full scale gray without the last palette colour");

  // Gray zero keeps red at the first stop.
  a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_gray_level == 8'd0 |-> out_red == PALETTE[0].r)
    else $error("zero gray with red away from the first palette stop");

endmodule

bind magnitude_to_db_colormap_pixel mdb_chk u_mdb_chk (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top
  import mdb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  // Levels after reset: floor -80 dB, ceiling 0 dB, in Q8.8.
  localparam logic [15:0] LEVEL_LO_RST = 16'hB000;
  localparam logic [15:0] LEVEL_HI_RST = 16'h0000;

  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_WORDS   = 100;
  localparam int HOLD_CYCLES   = 150;
  localparam int HOLD_AFTER    = 300;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // First and last colour stop, with the matching gray level.
  localparam pixel_t PIX_FIRST = {8'd0, 24'h440154};
  localparam pixel_t PIX_LAST  = {8'd255, 24'hDD323C};
  localparam pixel_t PIX_NONE  = '0;

  // round(256 * log2(1 + k / 64)) for the six bits below the leading one.
  localparam logic [7:0] FRAC_LOG2 [64] = '{
    8'd0,   8'd6,   8'd11,  8'd17,  8'd22,  8'd28,  8'd33,  8'd38,
    8'd44,  8'd49,  8'd54,  8'd59,  8'd63,  8'd68,  8'd73,  8'd78,
    8'd82,  8'd87,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113,
    8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
    8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd169, 8'd172, 8'd176,
    8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
    8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
    8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
  };

  // Colour stops as {red, green, blue}.
  localparam logic [23:0] VIRIDIS [16] = '{
    24'h440154, 24'h482374, 24'h404387, 24'h345E8D,
    24'h29788E, 24'h20908C, 24'h22A784, 24'h44BE70,
    24'h79D151, 24'hBDDE26, 24'hFDE724, 24'hFDC827,
    24'hFDA82E, 24'hFB8638, 24'hF3603C, 24'hDD323C
  };

  // One directed probe: the levels to use, the magnitude, and a typed
  // expectation where the answer is plain.
  typedef struct packed {
    logic [15:0] floor_q;
    logic [15:0] ceil_q;
    logic [31:0] mag;
    logic        known;
    pixel_t      want;
  } probe_t;

  localparam int N_PROBES = 25;
  localparam probe_t PROBES [N_PROBES] = '{
    '{16'hB000, 16'h0000, 32'h0000_0000, 1'b1, PIX_FIRST},
    '{16'hB000, 16'h0000, 32'hFFFF_FFFF, 1'b1, PIX_LAST},
    '{16'hB000, 16'h0000, 32'h0001_0000, 1'b1, PIX_LAST},
    '{16'hB000, 16'h0000, 32'h0000_0001, 1'b1, PIX_FIRST},
    '{16'hB000, 16'h0000, 32'h8000_0000, 1'b1, PIX_LAST},
    '{16'hB000, 16'h0000, 32'h0000_0002, 1'b0, PIX_NONE},
    '{16'hB000, 16'h0000, 32'h0000_003F, 1'b0, PIX_NONE},
    '{16'hB000, 16'h0000, 32'h0000_0100, 1'b0, PIX_NONE},
    '{16'hB000, 16'h0000, 32'h0000_1000, 1'b0, PIX_NONE},
    '{16'hB000, 16'h0000, 32'h0000_8000, 1'b0, PIX_NONE},
    '{16'hB000, 16'h0000, 32'h0000_C000, 1'b0, PIX_NONE},
    '{16'hB000, 16'h0000, 32'h0000_0AAA, 1'b0, PIX_NONE},
    '{16'hB000, 16'h0000, 32'h5555_5555, 1'b0, PIX_NONE},
    '{16'hB000, 16'h0000, 32'h0000_FFFF, 1'b0, PIX_NONE},
    '{16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, PIX_FIRST},
    '{16'h0000, 16'h0000, 32'h0001_0000, 1'b1, PIX_FIRST},
    '{16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 1'b1, PIX_FIRST},
    '{16'h7FFF, 16'h8000, 32'h0000_0001, 1'b1, PIX_FIRST},
    '{16'h8000, 16'h7FFF, 32'h0000_0000, 1'b1, PIX_FIRST},
    '{16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b0, PIX_NONE},
    '{16'h8000, 16'h7FFF, 32'h0000_0001, 1'b0, PIX_NONE},
    '{16'h8000, 16'h7FFF, 32'h0001_0000, 1'b0, PIX_NONE},
    '{16'h0000, 16'h0001, 32'h0001_0000, 1'b1, PIX_FIRST},
    '{16'hFFFF, 16'h0000, 32'h0001_0000, 1'b1, PIX_LAST},
    '{16'hFF00, 16'h0100, 32'h0001_3000, 1'b0, PIX_NONE}
  };

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [31:0]          in_magnitude = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [7:0]           out_gray_level;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  // Copy of the level registers as the block should hold them.
  logic [15:0] level_lo = LEVEL_LO_RST;
  logic [15:0] level_hi = LEVEL_HI_RST;

  pixel_t pending_pixels [$];
  int     pixels_seen = 0;
  int     mismatches  = 0;
  bit     tx_gaps     = 1'b1;
  bit     rx_gaps     = 1'b1;
  bit     hold_done   = 1'b0;

  magnitude_to_db_colormap_pixel dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_magnitude   (in_magnitude),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gray_level (out_gray_level),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // Gray level and colour of one magnitude under the given levels.
  function automatic pixel_t pixel_of_magnitude(input logic [31:0] mag,
                                                input logic signed [15:0] fl,
                                                input logic signed [15:0] cl);
    longint range, l2, db, n, t, x, fr, c_lo, c_hi, mix;
    int p, b, i, j, c;
    logic [5:0] idx;
    logic [23:0] rgb;
    range = cl - fl;
    t = 0;
    if (mag != 0 && range > 0) begin
      p = 0;
      for (b = 0; b < 32; b++) begin
        if (mag[b]) p = b;
      end
      if (p >= 6) idx = 6'(mag >> (p - 6));
      else idx = 6'(mag << (6 - p));
      l2 = longint'(p - 16) * 256 + longint'(FRAC_LOG2[idx]);
      // The arithmetic shift rounds towards minus infinity.
      db = (l2 * 1541) >>> 8;
      n = db - fl;
      if (n <= 0) t = 0;
      else if (n >= range) t = 65536;
      else t = (n * 65536) / range;
    end
    // Interpolate between the two stops either side of t.
    x = t * 15;
    i = int'(x >>> 16);
    if (i > 15) i = 15;
    fr = x & 64'hFFFF;
    j = (i < 15) ? i + 1 : 15;
    for (c = 0; c < 3; c++) begin
      c_lo = longint'(VIRIDIS[i][23 - 8 * c -: 8]);
      c_hi = longint'(VIRIDIS[j][23 - 8 * c -: 8]);
      mix = c_lo * (65536 - fr) + c_hi * fr;
      rgb[23 - 8 * c -: 8] = 8'(mix >>> 16);
    end
    return {8'((t * 255) >>> 16), rgb};
  endfunction

  // Magnitudes spread over every leading-one position, plus zero and raw words.
  function automatic logic [31:0] draw_magnitude();
    int unsigned sel, p;
    longint unsigned raw;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 32'h0;
    if (sel < 4) return $urandom();
    p = $urandom_range(0, 31);
    raw = longint'($urandom());
    raw = (raw & ((64'd1 << p) - 1)) | (64'd1 << p);
    return raw[31:0];
  endfunction

  // Offer one magnitude word and note the pixel it should give.
  task automatic offer_magnitude(input logic [31:0] mag, input logic typed,
                                 input pixel_t want);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_magnitude <= mag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) pending_pixels.push_back(want);
    else pending_pixels.push_back(pixel_of_magnitude(mag, level_lo, level_hi));
  endtask

  // Stop offering and wait until every pixel still due has come out.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Write both levels, each after a junk write to an undecoded index.
  task automatic program_levels(input logic [15:0] lo, input logic [15:0] hi);
    logic [CFG_IDX_W-1:0] idx_list [4];
    logic [15:0] data_list [4];
    int k;
    idx_list  = '{CFG_SPARE_A, CFG_DB_FLOOR, CFG_SPARE_B, CFG_DB_CEILING};
    data_list = '{16'($urandom()), lo, 16'($urandom()), hi};
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data  <= data_list[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    level_lo = lo;
    level_hi = hi;
  endtask

  // Receiver: a random stall (at times none) per word while rx_gaps is set, and one
  // long hold-off so that the pipeline fills and pushes back on the sender.
  initial begin : receiver
    int w;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!hold_done && pixels_seen >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      w = rx_gaps ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare every accepted pixel word with the oldest one still due.
  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        $error("pixel word with nothing due: gray_level %0d rgb %0d %0d %0d",
               out_gray_level, out_red, out_green, out_blue);
        mismatches++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_gray_level !== exp_px.gray) begin
          $error("gray_level: expected %0d, got %0d", exp_px.gray, out_gray_level);
          mismatches++;
        end
        if (out_red !== exp_px.red) begin
          $error("red: expected %0d, got %0d", exp_px.red, out_red);
          mismatches++;
        end
        if (out_green !== exp_px.green) begin
          $error("green: expected %0d, got %0d", exp_px.green, out_green);
          mismatches++;
        end
        if (out_blue !== exp_px.blue) begin
          $error("blue: expected %0d, got %0d", exp_px.blue, out_blue);
          mismatches++;
        end
      end
    end
  end

  // Give up if the run hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int r, ph, k, base, top;
    logic [15:0] lo, hi;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed probes; the first ones rely on the levels loaded by reset.
    for (r = 0; r < N_PROBES; r++) begin
      if (PROBES[r].floor_q != level_lo || PROBES[r].ceil_q != level_hi) begin
        drain_pixels();
        program_levels(PROBES[r].floor_q, PROBES[r].ceil_q);
      end
      offer_magnitude(PROBES[r].mag, PROBES[r].known, PROBES[r].want);
    end

    // Random phases, each under its own levels and idling pattern.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_pixels();
      case (ph)
        0: begin
          lo = 16'h8000;
          hi = 16'h7FFF;
        end
        1: begin
          lo = LEVEL_LO_RST;
          hi = LEVEL_HI_RST;
        end
        2: begin
          lo = 16'h7FFF;
          hi = 16'h8000;
        end
        3: begin
          lo = 16'($urandom());
          hi = lo;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            lo = 16'($urandom());
            hi = 16'($urandom());
          end else begin
            // Levels inside the span that magnitudes reach, narrow at times.
            base = int'($urandom_range(0, 46000)) - 26000;
            top = base + ((ph % 3 == 0) ? int'($urandom_range(1, 8))
                                        : int'($urandom_range(1, 30000)));
            if (top > 32767) top = 32767;
            lo = 16'(base);
            hi = 16'(top);
          end
        end
      endcase
      program_levels(lo, hi);
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_gaps = ($urandom_range(0, 2) != 0);
      for (k = 0; k < PHASE_WORDS; k++) begin
        // Once, the sender waits mid-phase for the pipeline to empty.
        if (ph == 6 && k == PHASE_WORDS / 2) drain_pixels();
        offer_magnitude(draw_magnitude(), 1'b0, PIX_NONE);
      end
    end

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/mdb_pkg.sv
rtl/mdb_log.sv
rtl/mdb_div_step.sv
rtl/mdb_cmap.sv
rtl/magnitude_to_db_colormap_pixel.sv
rtl/mdb_chk.sv
bench/tb_top.sv
